// ===== sv/lidar_ring_outlier_gate_defines.svh =====
// ---------------------------------------------------------------------------
// Lidar ring outlier gate assertion macros
// Shared concurrent assertion shorthands, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LIDAR_RING_OUTLIER_GATE_DEFINES_SVH
`define LIDAR_RING_OUTLIER_GATE_DEFINES_SVH

// Same-cycle implication.
`define LORG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lorg assertion failed");

// Next-cycle implication.
`define LORG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lorg assertion failed");

`endif

// ===== sv/lorg_pkg.sv =====
// ---------------------------------------------------------------------------
// Lidar ring outlier gate package
// Shared constants, register indexes and types of the outlier gate.
// ---------------------------------------------------------------------------
package lorg_pkg;

    localparam int MAX_POINTS = 2048;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int PPR_W      = 12;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    localparam logic [2:0] CFG_BAND_LOW    = 3'd0;
    localparam logic [2:0] CFG_BAND_HIGH   = 3'd1;
    localparam logic [2:0] CFG_ANGLE_LIMIT = 3'd2;
    localparam logic [2:0] CFG_RANGE_MIN   = 3'd3;
    localparam logic [2:0] CFG_RANGE_MAX   = 3'd4;
    localparam logic [2:0] CFG_GAP_LIMIT   = 3'd5;
    localparam logic [2:0] CFG_POINTS      = 3'd6;

    localparam logic [14:0]        RST_BAND_LOW    = 15'd8100;
    localparam logic [14:0]        RST_BAND_HIGH   = 15'd9500;
    localparam logic signed [15:0] RST_ANGLE_LIMIT = 16'sd12500;
    localparam logic [15:0]        RST_RANGE_MIN   = 16'd1600;
    localparam logic [15:0]        RST_RANGE_MAX   = 16'd5800;
    localparam logic [15:0]        RST_GAP_LIMIT   = 16'd100;
    localparam logic [PPR_W-1:0]   RST_POINTS      = PPR_W'(MAX_POINTS);

    typedef struct packed {
        logic [14:0]        band_low;
        logic [14:0]        band_high;
        logic signed [15:0] angle_limit;
        logic [15:0]        range_min;
        logic [15:0]        range_max;
        logic [15:0]        gap_limit;
        logic [PPR_W-1:0]   points_per_ring;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             has_prev;
        logic             prev_keep;
        logic             has_flush;
        logic             flush_keep;
    } entry_t;

endpackage

// ===== sv/lidar_ring_outlier_gate.sv =====
// ---------------------------------------------------------------------------
// Lidar ring outlier gate
// Marks lidar points as kept or rejected one ring behind the input stream.
// ---------------------------------------------------------------------------
// The slave stream carries one point per transaction, and the master stream
// returns the verdicts. A point of ring i is judged while the same index of
// ring i+1 arrives; points of a ring marked final also give their own band
// verdict at once, so one that has a previous ring yields two transactions.
// The configuration channel is always ready and should be written only while
// the block is idle; register indexes follow the register list, and writes to
// other indexes are dropped.
// A point is accepted every cycle while the result queue has room. Results
// pass the first stage and the queue. One result is sent per cycle while the
// receiver is ready, so the output side limits the final ring's point rate.
// A four-entry queue parts the two sides: when the receiver stalls, points
// are still taken until the queue is full. The line buffers are single-write
// memories of 2048 entries that the point counter addresses.
// Reset clears the ring and point counters, the queue and the configuration
// to its defaults; the line buffers are not cleared.
// ---------------------------------------------------------------------------
module lidar_ring_outlier_gate
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // angle [15:0], range [31:16]
    input  logic [1:0]  s_axis_tuser,   // cloud_start [0], final_ring [1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // point_index [10:0], zero [15:11]
    output logic [1:0]  m_axis_tuser,   // ring_select [0], keep [1]
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    lorg_pkg::cfg_t                cfg_reg;
    logic [lorg_pkg::QCNT_W-1:0]   space;
    logic                          push;
    lorg_pkg::entry_t              push_entry;
    logic [lorg_pkg::IDX_W-1:0]    point_index;
    logic                          ring_select;
    logic                          keep;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_low        <= lorg_pkg::RST_BAND_LOW;
            cfg_reg.band_high       <= lorg_pkg::RST_BAND_HIGH;
            cfg_reg.angle_limit     <= lorg_pkg::RST_ANGLE_LIMIT;
            cfg_reg.range_min       <= lorg_pkg::RST_RANGE_MIN;
            cfg_reg.range_max       <= lorg_pkg::RST_RANGE_MAX;
            cfg_reg.gap_limit       <= lorg_pkg::RST_GAP_LIMIT;
            cfg_reg.points_per_ring <= lorg_pkg::RST_POINTS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lorg_pkg::CFG_BAND_LOW:    cfg_reg.band_low    <= cfg_data[14:0];
                lorg_pkg::CFG_BAND_HIGH:   cfg_reg.band_high   <= cfg_data[14:0];
                lorg_pkg::CFG_ANGLE_LIMIT: cfg_reg.angle_limit <= signed'(cfg_data);
                lorg_pkg::CFG_RANGE_MIN:   cfg_reg.range_min   <= cfg_data;
                lorg_pkg::CFG_RANGE_MAX:   cfg_reg.range_max   <= cfg_data;
                lorg_pkg::CFG_GAP_LIMIT:   cfg_reg.gap_limit   <= cfg_data;
                lorg_pkg::CFG_POINTS:
                    cfg_reg.points_per_ring <= cfg_data[lorg_pkg::PPR_W-1:0];
                default: ;
            endcase
        end
    end

    lorg_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .angle       (signed'(s_axis_tdata[15:0])),
        .range       (s_axis_tdata[31:16]),
        .cloud_start (s_axis_tuser[0]),
        .final_ring  (s_axis_tuser[1]),
        .space       (space),
        .push        (push),
        .push_entry  (push_entry)
    );

    lorg_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_entry  (push_entry),
        .space       (space),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .point_index (point_index),
        .ring_select (ring_select),
        .keep        (keep),
        .last        (m_axis_tlast)
    );

    assign m_axis_tdata = {(16 - lorg_pkg::IDX_W)'(0), point_index};
    assign m_axis_tuser = {keep, ring_select};

endmodule

// ===== sv/lorg_front.sv =====
// ---------------------------------------------------------------------------
// Lidar ring outlier gate front end
// Counts points and rings, runs the band test, keeps the two line buffers
// and runs the neighbor ring gap test in the cycle after acceptance.
// ---------------------------------------------------------------------------
module lorg_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lorg_pkg::cfg_t             cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [15:0]         angle,
    input  logic [15:0]                range,
    input  logic                       cloud_start,
    input  logic                       final_ring,
    input  logic [lorg_pkg::QCNT_W-1:0] space,
    output logic                       push,
    output lorg_pkg::entry_t           push_entry
);

    logic [lorg_pkg::IDX_W:0]   point_counter_reg;
    logic [lorg_pkg::IDX_W:0]   point_counter_next;
    logic [1:0]                 rings_seen_reg;
    logic [1:0]                 rings_seen_next;

    logic [16:0]                prev_line_mem [lorg_pkg::MAX_POINTS];
    logic [15:0]                older_mem [lorg_pkg::MAX_POINTS];

    logic                       s1_valid_reg;
    logic [lorg_pkg::IDX_W-1:0] s1_idx_reg;
    logic [15:0]                s1_range_reg;
    logic                       s1_band_rej_reg;
    logic                       s1_final_reg;
    logic [1:0]                 s1_rings_reg;
    logic [16:0]                s1_prev_rd_reg;
    logic [15:0]                s1_older_rd_reg;

    logic                       accept;
    logic [lorg_pkg::CNT_W-1:0] ring_len;
    logic [lorg_pkg::CNT_W-1:0] pc_start;
    logic [lorg_pkg::CNT_W-1:0] pc_eff;
    logic [lorg_pkg::CNT_W-1:0] pc_inc;
    logic [lorg_pkg::IDX_W-1:0] j;
    logic [1:0]                 rings_eff;
    logic [15:0]                mag;
    logic                       band_rej;
    logic                       fwd_older;
    logic [15:0]                mid;
    logic [15:0]                diff_older;
    logic [15:0]                diff_next;
    logic                       gap_rej;

    assign in_ready = s1_valid_reg ? (space > lorg_pkg::QCNT_W'(1))
                                   : (space != '0);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (cfg.points_per_ring == '0)
        begin
            ring_len = lorg_pkg::CNT_W'(1);
        end
        else if (cfg.points_per_ring > lorg_pkg::PPR_W'(lorg_pkg::MAX_POINTS))
        begin
            ring_len = lorg_pkg::CNT_W'(lorg_pkg::MAX_POINTS);
        end
        else
        begin
            ring_len = lorg_pkg::CNT_W'(cfg.points_per_ring);
        end

        pc_start  = cloud_start ? '0 : point_counter_reg;
        rings_eff = cloud_start ? 2'd0 : rings_seen_reg;
        pc_eff    = (pc_start >= ring_len) ? '0 : pc_start;
        j         = pc_eff[lorg_pkg::IDX_W-1:0];
        pc_inc    = pc_eff + lorg_pkg::CNT_W'(1);

        if (pc_inc >= ring_len)
        begin
            point_counter_next = '0;
            if (final_ring)
            begin
                rings_seen_next = 2'd0;
            end
            else if (rings_eff < 2'd2)
            begin
                rings_seen_next = rings_eff + 2'd1;
            end
            else
            begin
                rings_seen_next = rings_eff;
            end
        end
        else
        begin
            point_counter_next = pc_inc;
            rings_seen_next    = rings_eff;
        end

        mag      = angle[15] ? 16'(-angle) : 16'(angle);
        band_rej = (mag > {1'b0, cfg.band_low} && mag < {1'b0, cfg.band_high})
                   || (angle > cfg.angle_limit)
                   || (range <= cfg.range_min)
                   || (range > cfg.range_max);

        fwd_older = s1_valid_reg && (s1_idx_reg == j);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_counter_reg <= '0;
            rings_seen_reg    <= 2'd0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                point_counter_reg <= point_counter_next;
                rings_seen_reg    <= rings_seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_prev_rd_reg   <= prev_line_mem[j];
            prev_line_mem[j] <= {band_rej, range};
            s1_older_rd_reg  <= fwd_older ? s1_prev_rd_reg[15:0] : older_mem[j];
            s1_idx_reg       <= j;
            s1_range_reg     <= range;
            s1_band_rej_reg  <= band_rej;
            s1_final_reg     <= final_ring;
            s1_rings_reg     <= rings_eff;
        end
        if (s1_valid_reg)
        begin
            older_mem[s1_idx_reg] <= s1_prev_rd_reg[15:0];
        end
    end

    always_comb
    begin
        mid        = s1_prev_rd_reg[15:0];
        diff_older = (mid > s1_older_rd_reg) ? (mid - s1_older_rd_reg)
                                             : (s1_older_rd_reg - mid);
        diff_next  = (mid > s1_range_reg) ? (mid - s1_range_reg)
                                          : (s1_range_reg - mid);
        gap_rej    = (s1_rings_reg >= 2'd2) && (diff_older > cfg.gap_limit)
                     && (diff_next > cfg.gap_limit);

        push_entry.idx        = s1_idx_reg;
        push_entry.has_prev   = (s1_rings_reg != 2'd0);
        push_entry.prev_keep  = !(s1_prev_rd_reg[16] || gap_rej);
        push_entry.has_flush  = s1_final_reg;
        push_entry.flush_keep = !s1_band_rej_reg;
        push = s1_valid_reg && (push_entry.has_prev || push_entry.has_flush);
    end

endmodule

// ===== sv/lorg_back.sv =====
// ---------------------------------------------------------------------------
// Lidar ring outlier gate back end
// Queues judged entries and sends out one or two results for each entry.
// ---------------------------------------------------------------------------
`include "lidar_ring_outlier_gate_defines.svh"

module lorg_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  lorg_pkg::entry_t            push_entry,
    output logic [lorg_pkg::QCNT_W-1:0] space,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lorg_pkg::IDX_W-1:0]  point_index,
    output logic                        ring_select,
    output logic                        keep,
    output logic                        last
);

    lorg_pkg::entry_t             queue_mem [lorg_pkg::QDEPTH];
    logic [lorg_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [lorg_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [lorg_pkg::QCNT_W-1:0]  count_reg;
    logic [lorg_pkg::QCNT_W-1:0]  count_next;
    logic                         phase_reg;
    logic                         phase_next;
    lorg_pkg::entry_t             head;
    logic                         both;
    logic                         emit_prev;
    logic                         take;
    logic                         pop;

    always_comb
    begin
        head        = queue_mem[rd_ptr_reg];
        both        = head.has_prev && head.has_flush;
        emit_prev   = head.has_prev && !phase_reg;
        m_valid     = (count_reg != '0);
        point_index = head.idx;
        ring_select = !emit_prev;
        keep        = emit_prev ? head.prev_keep : head.flush_keep;
        last        = emit_prev ? !head.has_flush : 1'b1;
        take        = m_valid && m_ready;
        pop         = take && !(both && !phase_reg);
        phase_next  = take ? (both && !phase_reg) : phase_reg;
        space       = lorg_pkg::QCNT_W'(lorg_pkg::QDEPTH) - count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + lorg_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - lorg_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            phase_reg <= phase_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + lorg_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + lorg_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= push_entry;
        end
    end

    `LORG_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= lorg_pkg::QCNT_W'(lorg_pkg::QDEPTH))
    `LORG_ASSERT_IMP(a_no_overflow, push && !pop, count_reg < lorg_pkg::QCNT_W'(lorg_pkg::QDEPTH))
    `LORG_ASSERT_IMP(a_phase_head, phase_reg, m_valid && head.has_prev && head.has_flush)
    `LORG_ASSERT_NEXT(a_phase_clear, take && phase_reg, !phase_reg)

endmodule
